>>> src/svaw_pkg.sv
// Shared types and constants for the smoothed value with angle wrap block.
`default_nettype none

package svaw_pkg;

  // Width of every value, Q(32-F).F signed.
  localparam int DATA_W = 32;

  // Default number of fraction bits; one full turn is 1 << FRACTION_BITS.
  localparam int FRACTION_BITS_DEFAULT = 16;

  // Item opcodes.
  typedef enum logic [1:0] {
    MODE_FORCE   = 2'd0,
    MODE_SET     = 2'd1,
    MODE_LINEAR  = 2'd2,
    MODE_ANGULAR = 2'd3
  } mode_e;

endpackage : svaw_pkg

`default_nettype wire

>>> src/svaw_step.sv
// One smoothing step: linear, or along the shorter arc with wrap into one turn.
`default_nettype none

module svaw_step import svaw_pkg::*; #(
  parameter int FracBits = FRACTION_BITS_DEFAULT
) (
  input  var mode_e                    mode_i,
  input  var logic signed [DATA_W-1:0] smoothed_i,
  input  var logic signed [DATA_W-1:0] target_i,
  input  var logic        [FracBits:0] amount_i,
  output var logic signed [DATA_W-1:0] smoothed_o
);

  localparam int DiffW = DATA_W + 1;
  localparam int AmtW  = FracBits + 1;
  localparam int ProdW = DiffW + AmtW + 1;
  localparam int AngW  = FracBits + 3;
  localparam int HalfTurn = 1 << (FracBits - 1);
  localparam int OneTurn  = 1 << FracBits;
  localparam logic signed [AngW-1:0] HALF_POS = AngW'(HalfTurn);
  localparam logic signed [AngW-1:0] HALF_NEG = -HALF_POS;
  localparam logic signed [AngW-1:0] ONE_TURN = AngW'(OneTurn);

  logic signed [FracBits:0]  s_rem;
  logic signed [FracBits:0]  t_rem;
  logic signed [AngW-1:0]    s_ang;
  logic signed [AngW-1:0]    t_ang;
  logic signed [AngW-1:0]    d_ang;
  logic signed [AngW-1:0]    d_wrap;
  logic signed [AngW-1:0]    s_wrap;
  logic                      near;
  logic                      wrap;
  logic signed [DiffW-1:0]   diff;
  logic signed [DiffW-1:0]   base;
  logic signed [ProdW-1:0]   prod;
  logic signed [ProdW-1:0]   prod_sh;
  logic signed [DiffW-1:0]   step;
  logic signed [DiffW:0]     sum;

  // Truncating remainder by one turn: keeps the sign of the dividend.
  assign s_rem = (smoothed_i[DATA_W-1] && (|smoothed_i[FracBits-1:0]))
               ? $signed({1'b1, smoothed_i[FracBits-1:0]})
               : $signed({1'b0, smoothed_i[FracBits-1:0]});
  assign t_rem = (target_i[DATA_W-1] && (|target_i[FracBits-1:0]))
               ? $signed({1'b1, target_i[FracBits-1:0]})
               : $signed({1'b0, target_i[FracBits-1:0]});

  assign s_ang = AngW'(s_rem);
  assign t_ang = AngW'(t_rem);
  assign d_ang = t_ang - s_ang;
  assign near  = (d_ang > HALF_NEG) && (d_ang < HALF_POS);

  // Far apart: lift the smaller end by one turn.
  always_comb begin
    if (t_ang > s_ang) begin
      s_wrap = s_ang + ONE_TURN;
      d_wrap = d_ang - ONE_TURN;
    end else begin
      s_wrap = s_ang;
      d_wrap = d_ang + ONE_TURN;
    end
  end

  // Operand select for the shared multiplier.
  always_comb begin
    wrap = 1'b0;
    case (mode_i)
      MODE_ANGULAR: begin
        if (near) begin
          diff = DiffW'(d_ang);
          base = DiffW'(s_ang);
        end else begin
          diff = DiffW'(d_wrap);
          base = DiffW'(s_wrap);
          wrap = 1'b1;
        end
      end
      default: begin
        diff = DiffW'(target_i) - DiffW'(smoothed_i);
        base = DiffW'(smoothed_i);
      end
    endcase
  end

  // floor(diff * a / 2^F); |step| <= |diff| so it fits diff's width.
  assign prod    = ProdW'(diff) * ProdW'($signed({1'b0, amount_i}));
  assign prod_sh = prod >>> FracBits;
  assign step    = $signed(prod_sh[DiffW-1:0]);
  assign sum     = (DiffW + 1)'(base) + (DiffW + 1)'(step);

  // Wrapped sum is reduced modulo one turn: the low fraction bits give 0..1 turn.
  assign smoothed_o = wrap ? $signed(DATA_W'(sum[FracBits-1:0]))
                           : $signed(sum[DATA_W-1:0]);

endmodule : svaw_step

`default_nettype wire

>>> src/smoothed_value_with_angle_wrap_core.sv
// Top level: smoothed value tracker with linear and angle-wrapped steps.
//
// Keeps a target, a smoothed value and a first-set flag in signed fixed point
// with FRACTION_BITS fraction bits; angles count one full turn as 1.0. Each
// transfer carries a mode: force both values (clears the first-set flag), set
// the target (the first set after a force also snaps the smoothed value),
// step the smoothed value linearly toward the target, or step it along the
// shorter arc, wrapping into 0..1 turn when it crosses the seam. The step
// fraction is clamped to 0..1.0 and the step is floor((e - v) * a / 2^F).
// Every input transfer yields one output transfer carrying both values after
// that item. Throughput is one item per clock while the output is not stalled.
// The input register loads at the input transfer edge; one pass through the
// single multiplier and adders then loads the state registers, which also
// serve as the output register, once the output slot is free. The state
// registers close the state loop, so consecutive items see each other's
// result with no bubble.
`default_nettype none

module smoothed_value_with_angle_wrap_core import svaw_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  var logic                     clk_i,
  input  var logic                     rst_ni,
  // input channel
  input  var logic                     in_valid_i,
  output var logic                     in_stall_o,
  input  var logic [1:0]               mode_i,
  input  var logic signed [DATA_W-1:0] new_value_i,
  input  var logic signed [DATA_W-1:0] amount_i,
  // output channel
  output var logic                     out_valid_o,
  input  var logic                     out_stall_i,
  output var logic signed [DATA_W-1:0] smoothed_value_o,
  output var logic signed [DATA_W-1:0] target_value_o
);

  localparam int OneTurn = 1 << FRACTION_BITS;
  localparam logic [DATA_W-1:0] ONE_TURN_W = DATA_W'(OneTurn);

  // Input register (payload, no reset)
  logic                     s1_valid_q, s1_valid_d;
  mode_e                    s1_mode_q;
  logic signed [DATA_W-1:0] s1_value_q;
  logic [FRACTION_BITS:0]   s1_amount_q;

  // Block state; it doubles as the result register.
  logic signed [DATA_W-1:0] target_q, target_d;
  logic signed [DATA_W-1:0] smoothed_q, smoothed_d;
  logic                     first_set_q, first_set_d;
  logic                     out_valid_q, out_valid_d;

  logic                     out_free;
  logic                     s1_adv;
  logic                     in_xfer;
  logic [FRACTION_BITS:0]   amount_clamp;
  logic signed [DATA_W-1:0] step_value;

  // Output slot frees when empty or when its transfer completes this edge.
  // State only moves when the slot frees, so it always matches what's shown.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Clamp the step fraction to 0..one turn before registering it.
  always_comb begin
    if (amount_i[DATA_W-1]) begin
      amount_clamp = '0;
    end else if ($unsigned(amount_i) > ONE_TURN_W) begin
      amount_clamp = ONE_TURN_W[FRACTION_BITS:0];
    end else begin
      amount_clamp = amount_i[FRACTION_BITS:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_mode_q   <= mode_e'(mode_i);
      s1_value_q  <= new_value_i;
      s1_amount_q <= amount_clamp;
    end
  end

  svaw_step #(
    .FracBits (FRACTION_BITS)
  ) u_step (
    .mode_i     (s1_mode_q),
    .smoothed_i (smoothed_q),
    .target_i   (target_q),
    .amount_i   (s1_amount_q),
    .smoothed_o (step_value)
  );

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    target_d    = target_q;
    smoothed_d  = smoothed_q;
    first_set_d = first_set_q;

    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    if (s1_adv) begin
      out_valid_d = 1'b1;
      case (s1_mode_q)
        MODE_FORCE: begin
          target_d    = s1_value_q;
          smoothed_d  = s1_value_q;
          first_set_d = 1'b0;
        end
        MODE_SET: begin
          target_d = s1_value_q;
          if (!first_set_q) begin
            first_set_d = 1'b1;
            smoothed_d  = s1_value_q;
          end
        end
        MODE_LINEAR,
        MODE_ANGULAR: begin
          smoothed_d = step_value;
        end
        default: begin
          smoothed_d = step_value;
        end
      endcase
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      target_q    <= '0;
      smoothed_q  <= '0;
      first_set_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      target_q    <= target_d;
      smoothed_q  <= smoothed_d;
      first_set_q <= first_set_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign smoothed_value_o = smoothed_q;
  assign target_value_o   = target_q;

endmodule : smoothed_value_with_angle_wrap_core

`default_nettype wire
